@@ src/sm3_pkg.sv @@
// SM3 stream hash: shared constants, command/status types and round helpers.
// No dependencies.
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned RoundCount = 64;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [255:0] IV_VALUE = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   // Byte-source codes for the block buffer write.
   localparam logic [1:0] SRC_MSG  = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;

   typedef struct packed {
      logic       put_byte;     // write one byte at fill position
      logic [1:0] byte_src;
      logic       count_byte;   // bump message length
      logic       put_len;      // write bit length into words 14, 15
      logic       start_comp;   // load round regs from chain, round 0
      logic       round_step;   // one round
      logic       chain_fold;   // chain ^= round regs
      logic       reset_msg;    // chain to IV, fill and length counters to zero
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       last_round;
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

@@ src/sm3_datapath.sv @@
// SM3 datapath: block buffer, 16-word expansion window, round registers, chain.
// Depends on sm3_pkg.
module sm3_datapath (
   input  logic               clock,
   input  logic               reset,
   input  sm3_pkg::cmd_type   cmd,
   input  logic [7:0]         msg_byte,
   output sm3_pkg::status_type status,
   output logic [255:0]       chain
);
   import sm3_pkg::*;

   logic [31:0]  blk_ff [BlockWords];
   logic [31:0]  win_ff [BlockWords];
   logic [31:0]  win_in [BlockWords];
   logic [255:0] chain_ff, chain_in;
   logic [31:0]  rr_ff [8];
   logic [31:0]  rr_in [8];
   logic [5:0]   fill_ff, fill_in;
   logic [5:0]   round_ff, round_in;
   logic [60:0]  total_ff, total_in;
   logic [7:0]   wbyte;
   logic [31:0]  w_new, wj, wj4, tj, a12, ss1, ss2, ff_v, gg_v, tt1, tt2;
   logic [63:0]  bits;

   assign bits = {total_ff, 3'b000};

   always_comb begin
      case (cmd.byte_src)
         SRC_MSG: wbyte = msg_byte;
         SRC_PAD: wbyte = PAD_BYTE;
         default: wbyte = 8'h00;
      endcase
   end

   // next expansion word from the sliding window (win[0] is w[j])
   assign w_new = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
                  ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   assign wj  = win_ff[0];
   assign wj4 = win_ff[4];
   assign tj  = (round_ff < 6'd16) ? rotl(T_LOW, round_ff[4:0]) : rotl(T_HIGH, round_ff[4:0]);
   assign a12 = rotl(rr_ff[0], 5'd12);
   assign ss1 = rotl(a12 + rr_ff[4] + tj, 5'd7);
   assign ss2 = ss1 ^ a12;
   always_comb begin
      if (round_ff < 6'd16) begin
         ff_v = rr_ff[0] ^ rr_ff[1] ^ rr_ff[2];
         gg_v = rr_ff[4] ^ rr_ff[5] ^ rr_ff[6];
      end else begin
         ff_v = (rr_ff[0] & rr_ff[1]) | (rr_ff[0] & rr_ff[2]) | (rr_ff[1] & rr_ff[2]);
         gg_v = (rr_ff[4] & rr_ff[5]) | (~rr_ff[4] & rr_ff[6]);
      end
   end
   assign tt1 = ff_v + rr_ff[3] + ss2 + (wj ^ wj4);
   assign tt2 = gg_v + rr_ff[7] + ss1 + wj;

   always_comb begin
      for (int i = 0; i < 8; i++) rr_in[i] = rr_ff[i];
      for (int i = 0; i < BlockWords; i++) win_in[i] = win_ff[i];
      chain_in = chain_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      total_in = total_ff;
      if (cmd.put_byte) fill_in = fill_ff + 6'd1;
      if (cmd.put_len)  fill_in = 6'd0;
      if (cmd.count_byte) total_in = total_ff + 61'd1;
      if (cmd.start_comp) begin
         for (int i = 0; i < 8; i++) rr_in[i] = chain_ff[255 - 32*i -: 32];
         for (int i = 0; i < BlockWords; i++) win_in[i] = blk_ff[i];
         round_in = 6'd0;
      end else if (cmd.round_step) begin
         rr_in[3] = rr_ff[2];
         rr_in[2] = rotl(rr_ff[1], 5'd9);
         rr_in[1] = rr_ff[0];
         rr_in[0] = tt1;
         rr_in[7] = rr_ff[6];
         rr_in[6] = rotl(rr_ff[5], 5'd19);
         rr_in[5] = rr_ff[4];
         rr_in[4] = perm0(tt2);
         for (int i = 0; i < BlockWords - 1; i++) win_in[i] = win_ff[i + 1];
         win_in[BlockWords - 1] = w_new;
         round_in = round_ff + 6'd1;
      end
      if (cmd.chain_fold) begin
         for (int i = 0; i < 8; i++)
            chain_in[255 - 32*i -: 32] = chain_ff[255 - 32*i -: 32] ^ rr_ff[i];
      end
      if (cmd.reset_msg) begin
         chain_in = IV_VALUE;
         fill_in  = 6'd0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= IV_VALUE;
         fill_ff  <= 6'd0;
         total_ff <= '0;
         round_ff <= 6'd0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) rr_ff[i] <= rr_in[i];
      for (int i = 0; i < BlockWords; i++) win_ff[i] <= win_in[i];
      if (cmd.put_byte)
         blk_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= wbyte;
      if (cmd.put_len) begin
         blk_ff[14] <= bits[63:32];
         blk_ff[15] <= bits[31:0];
      end
   end

   assign status.fill       = fill_ff;
   assign status.last_round = (round_ff == 6'(RoundCount - 1));
   assign chain             = chain_ff;
endmodule

@@ src/sm3_control.sv @@
// SM3 controller: accepts bytes, sequences padding, compressions and digest output.
// Depends on sm3_pkg.
module sm3_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                byte_valid,
   input  logic                end_of_msg,
   input  sm3_pkg::status_type status,
   output sm3_pkg::cmd_type    cmd,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          part_index
);
   import sm3_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FOLD  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_LEN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;     // message is finishing
   logic       lenw_ff, lenw_in;   // length written: next fold ends message
   logic [1:0] part_ff, part_in;
   logic       padcont_ff, padcont_in; // padding started: a fold goes back to pad
   logic       acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign part_index = part_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      fin_in = fin_ff;
      lenw_in = lenw_ff;
      part_in = part_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (byte_valid) begin
                  cmd.put_byte = 1'b1;
                  cmd.byte_src = SRC_MSG;
                  cmd.count_byte = 1'b1;
               end
               fin_in = end_of_msg;
               lenw_in = 1'b0;
               if (byte_valid && status.fill == 6'd63) state_in = ST_LOAD;
               else if (end_of_msg) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // 0x80 then zeros to word 14 (or to block end if already at byte 56 or beyond)
            cmd.put_byte = 1'b1;
            cmd.byte_src = (fin_ff) ? SRC_PAD : SRC_ZERO;
            fin_in = 1'b0;
            if (status.fill == 6'd63) state_in = ST_LOAD;
            else if (status.fill == 6'd55) state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.put_len = 1'b1;
            lenw_in = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.start_comp = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.last_round) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.chain_fold = 1'b1;
            if (lenw_ff) begin
               part_in = 2'd0;
               state_in = ST_OUT;
            end else if (fin_ff) state_in = ST_PAD;
            // after a data block: idle; after a block in which padding began: more pad
            else state_in = (padcont_ff) ? ST_PAD : ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  cmd.reset_msg = 1'b1;
                  lenw_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      padcont_in = padcont_ff;
      if (state_ff == ST_IDLE && acc) padcont_in = 1'b0;
      if (state_ff == ST_PAD) padcont_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fin_ff     <= 1'b0;
         lenw_ff    <= 1'b0;
         part_ff    <= 2'd0;
         padcont_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fin_ff     <= fin_in;
         lenw_ff    <= lenw_in;
         part_ff    <= part_in;
         padcont_ff <= padcont_in;
      end
   end
endmodule

@@ src/sm3_hash_stream.sv @@
// SM3 stream hash top level: controller plus datapath.
// Depends on sm3_pkg, sm3_control, sm3_datapath.
//
// Takes a message one byte per transaction (req_byte_valid low with
// req_end_of_msg high ends a message without adding a byte). A byte is
// accepted while req_stall is low; the 64th byte of a block starts a
// compression (load, 64 rounds on one shared round unit, fold into the
// chain) during which req_stall is high. On end of message the block writes
// padding one byte per cycle up to byte 56 (or 64 plus a second block),
// the length, compresses, and then offers the digest as four rsp
// transactions, part 0 first, each two big-endian words. The chain then
// returns to the IV.
module sm3_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_msg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part,
   output logic [1:0]  rsp_part_index,
   output logic        rsp_last_part
);
   import sm3_pkg::*;

   cmd_type      cmd;
   status_type   status;
   logic [255:0] chain;

   sm3_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .byte_valid (req_byte_valid),
      .end_of_msg (req_end_of_msg),
      .status, .cmd, .rsp_valid, .rsp_stall,
      .part_index (rsp_part_index)
   );

   sm3_datapath u_dp (
      .clock, .reset, .cmd,
      .msg_byte (req_msg_byte),
      .status, .chain
   );

   // part k holds chain words 2k and 2k+1
   assign rsp_digest_part = chain[255 - 64*rsp_part_index -: 64];
   assign rsp_last_part   = (rsp_part_index == 2'd3);
endmodule

@@ src/sm3_hash_stream_checker.sv @@
// Port-level checks for sm3_hash_stream, bound to the top level.
// Depends on sm3_hash_stream.
module sm3_hash_stream_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_part_index,
   input logic       rsp_last_part
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_part == (rsp_part_index == 2'd3)))
      else $error("last_part mismatch");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during output");
   a_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_part) |=>
      (rsp_valid && rsp_part_index == $past(rsp_part_index) + 2'd1))
      else $error("part sequence broken");
endmodule

bind sm3_hash_stream sm3_hash_stream_checker u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_part_index, .rsp_last_part
);
